### rtl/ipe24_pkg.sv
// Shared types and constants of the indexed palette expander.
package ipe24_pkg;

   // Transaction kinds on the request channel (carried in tuser).
   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_DATA    = 1'b1;

   // Pixel depth codes of the pixel_mode register.
   localparam logic [1:0] MODE_1BPP = 2'd0;
   localparam logic [1:0] MODE_4BPP = 2'd1;
   localparam logic [1:0] MODE_8BPP = 2'd2;

   // Register indexes; register i sits at byte address 4*i.
   localparam logic [1:0] REG_PIXEL_MODE   = 2'd0;
   localparam logic [1:0] REG_ROW_WIDTH    = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int DIM_W       = 13;
   localparam int ROW_CNT_W   = 12;
   localparam int MAX_HEIGHT  = 4096;
   localparam int RGB_W       = 24;
   localparam int BYTE_W      = 8;

   typedef struct packed {
      logic last_of_byte;
      logic row_end;
      logic frame_end;
   } pix_flags_type;

   // One pixel lookup issued by the unpacker.
   typedef struct packed {
      logic                valid;
      logic [BYTE_W-1:0]   pix;
      pix_flags_type       flags;
   } lookup_req_type;

   // One expanded pixel; rgb holds red in the high byte, blue in the low byte.
   typedef struct packed {
      logic [RGB_W-1:0] rgb;
      pix_flags_type    flags;
   } pixel_type;

endpackage

### rtl/ipe24_csr.sv
// Configuration registers of the palette expander with their derived row and column limits.
module ipe24_csr #(
   parameter int MAX_ROW_WIDTH = 4096,
   parameter int COL_W         = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ipe24_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ipe24_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ipe24_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output logic [1:0]                          pixel_mode,
   output logic [COL_W-1:0]                    width_m1,
   output logic [ipe24_pkg::ROW_CNT_W-1:0]     height_m1
);

   localparam int LW = ((COL_W > ipe24_pkg::DIM_W) ? COL_W : ipe24_pkg::DIM_W) + 1;

   logic [1:0]                       pixel_mode_ff;
   logic [ipe24_pkg::DIM_W-1:0]      row_width_ff;
   logic [ipe24_pkg::DIM_W-1:0]      image_height_ff;
   logic [COL_W-1:0]                 width_m1_ff, width_m1_in;
   logic [ipe24_pkg::ROW_CNT_W-1:0]  height_m1_ff, height_m1_in;
   logic [1:0]                       reg_index;
   logic                             wr_en;
   logic [LW-1:0]                    w_ext;
   logic [ipe24_pkg::DIM_W-1:0]      h_val;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Zero counts as one; values above the maximum saturate.
   always_comb begin
      w_ext = LW'(csr_pwdata[ipe24_pkg::DIM_W-1:0]);
      if (w_ext == '0) begin
         width_m1_in = '0;
      end else if (w_ext > LW'(MAX_ROW_WIDTH)) begin
         width_m1_in = COL_W'(MAX_ROW_WIDTH - 1);
      end else begin
         width_m1_in = COL_W'(w_ext - LW'(1));
      end
   end

   always_comb begin
      h_val = csr_pwdata[ipe24_pkg::DIM_W-1:0];
      if (h_val == '0) begin
         height_m1_in = '0;
      end else if (h_val > ipe24_pkg::DIM_W'(ipe24_pkg::MAX_HEIGHT)) begin
         height_m1_in = ipe24_pkg::ROW_CNT_W'(ipe24_pkg::MAX_HEIGHT - 1);
      end else begin
         height_m1_in = ipe24_pkg::ROW_CNT_W'(h_val - ipe24_pkg::DIM_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff   <= ipe24_pkg::MODE_8BPP;
         row_width_ff    <= ipe24_pkg::DIM_W'(1);
         image_height_ff <= ipe24_pkg::DIM_W'(1);
         width_m1_ff     <= '0;
         height_m1_ff    <= '0;
      end else if (wr_en) begin
         case (reg_index)
            ipe24_pkg::REG_PIXEL_MODE: begin
               pixel_mode_ff <= csr_pwdata[1:0];
            end
            ipe24_pkg::REG_ROW_WIDTH: begin
               row_width_ff <= csr_pwdata[ipe24_pkg::DIM_W-1:0];
               width_m1_ff  <= width_m1_in;
            end
            ipe24_pkg::REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_pwdata[ipe24_pkg::DIM_W-1:0];
               height_m1_ff    <= height_m1_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         ipe24_pkg::REG_PIXEL_MODE:   csr_prdata = ipe24_pkg::CSR_DATA_W'(pixel_mode_ff);
         ipe24_pkg::REG_ROW_WIDTH:    csr_prdata = ipe24_pkg::CSR_DATA_W'(row_width_ff);
         ipe24_pkg::REG_IMAGE_HEIGHT: csr_prdata = ipe24_pkg::CSR_DATA_W'(image_height_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   assign pixel_mode = pixel_mode_ff;
   assign width_m1   = width_m1_ff;
   assign height_m1  = height_m1_ff;

endmodule

### rtl/ipe24_unpack.sv
// Byte holding stage that splits a packed byte into pixel indices and tracks row and column.
module ipe24_unpack #(
   parameter int COL_W = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [ipe24_pkg::BYTE_W-1:0]      data_byte,
   input  logic [1:0]                        pixel_mode,
   input  logic [COL_W-1:0]                  width_m1,
   input  logic [ipe24_pkg::ROW_CNT_W-1:0]   height_m1,
   input  logic                              advance,
   output logic                              ready,
   output ipe24_pkg::lookup_req_type         lookup
);

   logic                              busy_ff;
   logic [ipe24_pkg::BYTE_W-1:0]      shift_ff, shift_in;
   logic [2:0]                        pos_ff;
   logic [2:0]                        per_byte_m1;
   logic [COL_W-1:0]                  col_ff;
   logic [ipe24_pkg::ROW_CNT_W-1:0]   row_ff;
   logic                              issue;
   logic                              rend, fend, last;
   logic [ipe24_pkg::BYTE_W-1:0]      pix;

   always_comb begin
      case (pixel_mode)
         ipe24_pkg::MODE_1BPP: begin
            pix         = ipe24_pkg::BYTE_W'(shift_ff[7]);
            per_byte_m1 = 3'd7;
            shift_in    = shift_ff << 1;
         end
         ipe24_pkg::MODE_4BPP: begin
            pix         = ipe24_pkg::BYTE_W'(shift_ff[7:4]);
            per_byte_m1 = 3'd1;
            shift_in    = shift_ff << 4;
         end
         default: begin
            pix         = shift_ff;
            per_byte_m1 = 3'd0;
            shift_in    = shift_ff;
         end
      endcase
   end

   assign issue = busy_ff && advance;
   assign rend  = (col_ff >= width_m1);
   assign fend  = rend && (row_ff >= height_m1);
   assign last  = rend || (pos_ff == per_byte_m1);
   assign ready = !busy_ff || (issue && last);

   assign lookup.valid              = issue;
   assign lookup.pix                = pix;
   assign lookup.flags.last_of_byte = last;
   assign lookup.flags.row_end      = rend;
   assign lookup.flags.frame_end    = fend;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
            pos_ff  <= '0;
         end else if (issue && last) begin
            busy_ff <= 1'b0;
         end else if (issue) begin
            pos_ff <= pos_ff + 3'd1;
         end
         if (issue) begin
            if (rend) begin
               col_ff <= '0;
               row_ff <= fend ? '0 : row_ff + ipe24_pkg::ROW_CNT_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      if (load) begin
         shift_ff <= data_byte;
      end else if (issue) begin
         shift_ff <= shift_in;
      end
   end

   a_row_end_drops_rest: assert property (@(posedge clock) disable iff (reset)
      issue && rend |=> !busy_ff || $past(load))
      else $error("pixels kept after the end of a row");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pos_ff <= per_byte_m1)
      else $error("pixel position past the end of the byte");

endmodule

### rtl/ipe24_palette.sv
// Palette memory with its registered lookup stage.
module ipe24_palette #(
   parameter int PAL_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [ipe24_pkg::BYTE_W-1:0]      wr_index,
   input  logic [ipe24_pkg::RGB_W-1:0]       wr_rgb,
   input  ipe24_pkg::lookup_req_type         lookup,
   input  logic                              out_ready,
   output logic                              advance,
   output logic                              out_valid,
   output ipe24_pkg::pixel_type              out_pixel
);

   localparam int IW = $clog2(PAL_DEPTH);

   logic [ipe24_pkg::RGB_W-1:0] mem [PAL_DEPTH];
   logic [ipe24_pkg::RGB_W-1:0] rd_data_ff;
   logic                        valid_ff;
   logic                        in_range_ff;
   ipe24_pkg::pix_flags_type    flags_ff;
   logic                        wr_in_range;
   logic                        rd_in_range;

   assign wr_in_range = ({1'b0, wr_index} < 9'(PAL_DEPTH));
   assign rd_in_range = ({1'b0, lookup.pix} < 9'(PAL_DEPTH));
   assign advance     = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (wr_en && wr_in_range) begin
         mem[wr_index[IW-1:0]] <= wr_rgb;
      end
      if (lookup.valid) begin
         rd_data_ff  <= mem[lookup.pix[IW-1:0]];
         in_range_ff <= rd_in_range;
         flags_ff    <= lookup.flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (lookup.valid) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Indices beyond the palette read as black.
   assign out_valid       = valid_ff;
   assign out_pixel.rgb   = in_range_ff ? rd_data_ff : '0;
   assign out_pixel.flags = flags_ff;

   a_lookup_only_when_free: assert property (@(posedge clock) disable iff (reset)
      lookup.valid |-> !valid_ff || out_ready)
      else $error("lookup issued over a pixel that was not taken");

   a_stalled_pixel_held: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(flags_ff))
      else $error("stalled pixel lost in the lookup stage");

endmodule

### rtl/ipe24_out_skid.sv
// Two-entry output register that decouples the result channel from the lookup stage.
module ipe24_out_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  ipe24_pkg::pixel_type   in_pixel,
   output logic                   in_ready,
   output logic                   out_valid,
   output ipe24_pkg::pixel_type   out_pixel,
   input  logic                   out_ready
);

   logic                 main_valid_ff;
   logic                 skid_valid_ff;
   ipe24_pkg::pixel_type main_ff;
   ipe24_pkg::pixel_type skid_ff;
   logic                 take_in;
   logic                 main_free;

   assign in_ready  = !skid_valid_ff;
   assign take_in   = in_valid && in_ready;
   assign main_free = !main_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= take_in;
         end
      end else if (take_in) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_free) begin
         main_ff <= skid_valid_ff ? skid_ff : in_pixel;
      end else if (take_in) begin
         skid_ff <= in_pixel;
      end
   end

   assign out_valid = main_valid_ff;
   assign out_pixel = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry filled while the output register is empty");

endmodule

### rtl/indexed_palette_expand_24bpp_top.sv
// Top level of the indexed palette expander: packed 1, 4 or 8 bit pixels to 24-bit color.
//
// The block takes two kinds of request transactions, told apart by req_tuser. A palette
// write stores one 24-bit color at the given index and produces nothing; one can be taken
// every cycle while no byte is in progress. A data transaction carries one packed byte,
// first pixel in the high bits, and produces one color per pixel: eight at 1 bit per
// pixel, two at 4 bits, one at 8 bits, fewer when the row ends inside the byte (the rest
// of that byte is dropped and the next byte opens the next row). Each pixel goes through
// the single read port of the palette memory, one pixel per cycle while the result
// channel does not stall, and the next byte is taken in the cycle its predecessor issues
// its last pixel. The first pixel of a byte passes the byte, lookup and output registers
// before it leaves. A two-entry output register sits in front of the result channel, so
// rsp_tready has no combinational path to req_tready. Palette entries read before they
// were ever written return unspecified data; indices beyond the palette read as black.
// Result transactions flag the last pixel of each byte, row and frame; rows and frames
// are counted from reset, and the registers must be written only while the block is idle.
// Registers: pixel_mode at 0x0, row_width at 0x4, image_height at 0x8 (zero counts as one,
// larger values than the maximum saturate).
module indexed_palette_expand_24bpp_top #(
   parameter int PAL_DEPTH     = 256,
   parameter int MAX_ROW_WIDTH = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // palette_index [7:0], red_in [15:8], green_in [23:16], blue_in [31:24], data_byte [39:32]
   input  logic [39:0]                       req_tdata,
   // opcode [0]
   input  logic [0:0]                        req_tuser,
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // blue_out [7:0], green_out [15:8], red_out [23:16]
   output logic [23:0]                       rsp_tdata,
   // row_end
   output logic                              rsp_tlast,
   // last_of_byte [0], frame_end [1]
   output logic [1:0]                        rsp_tuser,
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ipe24_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ipe24_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ipe24_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);

   // Column counter width; it never holds more than the widest row minus one.
   localparam int COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;

   logic [1:0]                        pixel_mode;
   logic [COL_W-1:0]                  width_m1;
   logic [ipe24_pkg::ROW_CNT_W-1:0]   height_m1;
   logic                              req_accept;
   logic                              data_load;
   logic                              palette_write;
   logic                              lookup_advance;
   ipe24_pkg::lookup_req_type         lookup;
   logic                              px_valid;
   ipe24_pkg::pixel_type              px;
   logic                              skid_ready;
   ipe24_pkg::pixel_type              rsp_pixel;

   // A transaction is taken only when no byte is left holding pixels that would still read
   // the palette, so a palette write can never overtake an earlier pixel.
   assign req_accept    = req_tvalid && req_tready;
   assign data_load     = req_accept && (req_tuser[0] == ipe24_pkg::OP_DATA);
   assign palette_write = req_accept && (req_tuser[0] == ipe24_pkg::OP_PALETTE);

   ipe24_csr #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
      .COL_W         (COL_W)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pixel_mode  (pixel_mode),
      .width_m1    (width_m1),
      .height_m1   (height_m1)
   );

   ipe24_unpack #(
      .COL_W (COL_W)
   ) u_unpack (
      .clock      (clock),
      .reset      (reset),
      .load       (data_load),
      .data_byte  (req_tdata[39:32]),
      .pixel_mode (pixel_mode),
      .width_m1   (width_m1),
      .height_m1  (height_m1),
      .advance    (lookup_advance),
      .ready      (req_tready),
      .lookup     (lookup)
   );

   // The palette stores red in the high byte and blue in the low byte.
   ipe24_palette #(
      .PAL_DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (palette_write),
      .wr_index  (req_tdata[7:0]),
      .wr_rgb    ({req_tdata[15:8], req_tdata[23:16], req_tdata[31:24]}),
      .lookup    (lookup),
      .out_ready (skid_ready),
      .advance   (lookup_advance),
      .out_valid (px_valid),
      .out_pixel (px)
   );

   ipe24_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (px_valid),
      .in_pixel  (px),
      .in_ready  (skid_ready),
      .out_valid (rsp_tvalid),
      .out_pixel (rsp_pixel),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata    = rsp_pixel.rgb;
   assign rsp_tlast    = rsp_pixel.flags.row_end;
   assign rsp_tuser[0] = rsp_pixel.flags.last_of_byte;
   assign rsp_tuser[1] = rsp_pixel.flags.frame_end;

   // A frame can only end on the last pixel of a row, which also ends its byte.
   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && rsp_tuser[0])
      else $error("frame end flagged away from a row end");

endmodule
